/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on the rising edge, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`else

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_SAME(lbl, clk, rst, ante, cons)

`endif

`endif

/* hdl/hps_pkg.sv */
// ---------------------------------------------------------------------------
// hps_pkg
// Shared widths, register indexes, payload types and the rounding adder.
// ---------------------------------------------------------------------------
package hps_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_DEGREE = 6;
   localparam int NUM_COEF   = MAX_DEGREE + 1;
   localparam int DEG_W      = 3;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int NUM_REGS   = NUM_COEF + 1;
   localparam int CSR_IDX_W  = $clog2(NUM_REGS);
   localparam int COEF_IDX_W = $clog2(NUM_COEF);

   localparam logic [CSR_IDX_W-1:0] REG_DEGREE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COEF_BASE = CSR_IDX_W'(1);

   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] x_value;
      logic signed [DATA_W-1:0] direction;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] poly_value;
      logic signed [DATA_W-1:0] slope_times_dir;
      logic                     saturated;
   } rsp_type;

   // one item on its way down the Horner chain
   typedef struct packed {
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] h;
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] dacc;
      logic              sat;
   } item_type;

   // coefficients as the datapath sees them: zero above the degree in use
   typedef struct packed {
      logic [NUM_COEF-1:0][DATA_W-1:0] coef;
      logic [NUM_COEF-1:0][DATA_W-1:0] dcoef;
      logic [NUM_COEF-1:0]             dsat;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              clip;
   } sum_type;

   // round product half up to FRAC_BITS, add addend, clip to DATA_W
   function automatic sum_type round_add_sat(input logic signed [PROD_W-1:0] prod,
                                             input logic [DATA_W-1:0] addend);
      logic signed [PROD_W-1:0] rounded;
      logic signed [PROD_W-1:0] total;
      logic [PROD_W-DATA_W:0]   top_bits;
      sum_type                  res;
      rounded  = (prod + RND_HALF) >>> FRAC_BITS;
      total    = rounded + {{(PROD_W-DATA_W){addend[DATA_W-1]}}, addend};
      top_bits = total[PROD_W-1:DATA_W-1];
      if (top_bits == '0 || top_bits == '1) begin
         res.value = total[DATA_W-1:0];
         res.clip  = 1'b0;
      end else if (total[PROD_W-1]) begin
         res.value = DATA_MIN;
         res.clip  = 1'b1;
      end else begin
         res.value = DATA_MAX;
         res.clip  = 1'b1;
      end
      return res;
   endfunction

endpackage

/* hdl/hps_coef_regs.sv */
// ---------------------------------------------------------------------------
// hps_coef_regs
// Degree and coefficient registers, with masked and scaled copies.
// ---------------------------------------------------------------------------
module hps_coef_regs import hps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   localparam int SCL_W = DATA_W + DEG_W + 1;

   logic [DEG_W-1:0]                degree_ff;
   logic [DEG_W-1:0]                degree_in;
   logic [NUM_COEF-1:0][DATA_W-1:0] coef_ff;
   logic [NUM_COEF-1:0][DATA_W-1:0] coef_in;
   logic [COEF_IDX_W-1:0]           coef_sel;
   logic [DEG_W-1:0]                deg_eff;

   assign coef_sel = COEF_IDX_W'(csr_index - REG_COEF_BASE);

   always_comb begin
      degree_in = degree_ff;
      coef_in   = coef_ff;
      if (csr_we) begin
         if (csr_index == REG_DEGREE) begin
            degree_in = csr_wdata[DEG_W-1:0];
         end else if (int'(csr_index) < NUM_REGS) begin
            coef_in[coef_sel] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
         coef_ff   <= '0;
      end else begin
         degree_ff <= degree_in;
         coef_ff   <= coef_in;
      end
   end

   // degree beyond the pipeline length runs at full length
   assign deg_eff = (int'(degree_ff) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : degree_ff;

   // leading zero terms leave Horner's rule exact, so unused terms read zero
   always_comb begin
      logic [SCL_W-1:0]        scaled;
      logic [SCL_W-DATA_W:0]   top_bits;
      logic                    in_use;
      cfg = '0;
      for (int k = 0; k < NUM_COEF; k++) begin
         in_use      = (int'(deg_eff) >= k);
         cfg.coef[k] = in_use ? coef_ff[k] : '0;
         scaled      = {{(SCL_W-DATA_W){coef_ff[k][DATA_W-1]}}, coef_ff[k]} * SCL_W'(k);
         top_bits    = scaled[SCL_W-1:DATA_W-1];
         if (!in_use) begin
            cfg.dcoef[k] = '0;
            cfg.dsat[k]  = 1'b0;
         end else if (top_bits == '0 || top_bits == '1) begin
            cfg.dcoef[k] = scaled[DATA_W-1:0];
            cfg.dsat[k]  = 1'b0;
         end else begin
            cfg.dcoef[k] = scaled[SCL_W-1] ? DATA_MIN : DATA_MAX;
            cfg.dsat[k]  = 1'b1;
         end
      end
   end

endmodule

/* hdl/hps_step.sv */
// ---------------------------------------------------------------------------
// hps_step
// One Horner step for value and derivative: multiply stage, then round/add.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hps_step import hps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  item_type          in_item,
   input  logic [DATA_W-1:0] coef,
   input  logic [DATA_W-1:0] dcoef,
   input  logic              dsat,
   input  logic              deriv_en,
   output logic              out_valid,
   input  logic              out_ready,
   output item_type          out_item
);

   logic                     a_valid_ff;
   logic                     a_valid_in;
   item_type                 a_item_ff;
   logic signed [PROD_W-1:0] a_prod_p_ff;
   logic signed [PROD_W-1:0] a_prod_p_in;
   logic signed [PROD_W-1:0] a_prod_d_ff;
   logic signed [PROD_W-1:0] a_prod_d_in;
   logic                     b_valid_ff;
   logic                     b_valid_in;
   item_type                 b_item_ff;
   item_type                 b_item_in;
   logic                     a_ready;
   logic                     b_ready;
   sum_type                  p_sum;
   sum_type                  d_sum;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_valid_in  = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in  = b_ready ? a_valid_ff : b_valid_ff;
   assign a_prod_p_in = $signed(in_item.acc) * $signed(in_item.x);
   assign a_prod_d_in = $signed(in_item.dacc) * $signed(in_item.x);

   always_comb begin
      p_sum         = round_add_sat(a_prod_p_ff, coef);
      d_sum         = round_add_sat(a_prod_d_ff, dcoef);
      b_item_in     = a_item_ff;
      b_item_in.acc = p_sum.value;
      if (deriv_en) begin
         b_item_in.dacc = d_sum.value;
      end
      b_item_in.sat = a_item_ff.sat | p_sum.clip | (deriv_en & (d_sum.clip | dsat));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_item_ff   <= in_item;
         a_prod_p_ff <= a_prod_p_in;
         a_prod_d_ff <= a_prod_d_in;
      end
      if (b_ready && a_valid_ff) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

   `ASSERT_NEXT(a_hold_chk, clock, reset, a_valid_ff && !b_ready, a_valid_ff && $stable(a_prod_p_ff) && $stable(a_prod_d_ff))
   `ASSERT_NEXT(b_hold_chk, clock, reset, b_valid_ff && !out_ready, b_valid_ff && $stable(b_item_ff))
   `ASSERT_NEXT(a_fill_chk, clock, reset, in_valid && in_ready, a_valid_ff)

endmodule

/* hdl/hps_slope.sv */
// ---------------------------------------------------------------------------
// hps_slope
// Final stage: derivative times direction, rounded, clipped; result register.
// ---------------------------------------------------------------------------
module hps_slope import hps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_rsp
);

   logic                     a_valid_ff;
   logic                     a_valid_in;
   item_type                 a_item_ff;
   logic signed [PROD_W-1:0] a_prod_ff;
   logic signed [PROD_W-1:0] a_prod_in;
   logic                     b_valid_ff;
   logic                     b_valid_in;
   rsp_type                  b_rsp_ff;
   rsp_type                  b_rsp_in;
   logic                     a_ready;
   logic                     b_ready;
   sum_type                  s_sum;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign a_prod_in  = $signed(in_item.dacc) * $signed(in_item.h);

   // zero derivative gives a zero slope, so degree zero needs no special path
   always_comb begin
      s_sum                    = round_add_sat(a_prod_ff, '0);
      b_rsp_in.poly_value      = a_item_ff.acc;
      b_rsp_in.slope_times_dir = s_sum.value;
      b_rsp_in.saturated       = a_item_ff.sat | s_sum.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_item_ff <= in_item;
         a_prod_ff <= a_prod_in;
      end
      if (b_ready && a_valid_ff) begin
         b_rsp_ff <= b_rsp_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_rsp   = b_rsp_ff;

endmodule

/* hdl/horner_poly_and_slope.sv */
// ---------------------------------------------------------------------------
// horner_poly_and_slope
// Pipelined polynomial value and scaled slope by Horner's rule, Q16.16.
// ---------------------------------------------------------------------------
//
//   channel   direction   handshake          payload
//   req_      in          valid / ready      req_type  (x_value, direction)
//   rsp_      out         valid / ready      rsp_type  (poly_value,
//                                                       slope_times_dir,
//                                                       saturated)
//   csr_      in          write enable only  index, 32-bit write data
//
// One transfer in and one out per cycle while rsp_ready is high. The pipeline
// is six Horner steps and the slope stage, each a multiply register followed
// by a round/add/clip register, so one 32x32 multiply sets the cycle.
// Every stage has its own valid bit and ready; a stalled output holds only
// the stages that are full, so bubbles close up and transfers keep coming.
// Synchronous reset empties the pipeline and clears degree and coefficients.
//
// ---------------------------------------------------------------------------
module horner_poly_and_slope import hps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   cfg_type  cfg;

   // element j feeds Horner step j; element MAX_DEGREE feeds the slope stage
   logic     stage_valid [MAX_DEGREE+1];
   logic     stage_ready [MAX_DEGREE+1];
   item_type stage_item  [MAX_DEGREE+1];

   hps_coef_regs u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Horner is always run at full length: terms above the degree read zero,
   // which keeps the accumulators at zero until the top term in use.
   assign stage_item[0].x    = req_data.x_value;
   assign stage_item[0].h    = req_data.direction;
   assign stage_item[0].acc  = cfg.coef[MAX_DEGREE];
   assign stage_item[0].dacc = cfg.dcoef[MAX_DEGREE];
   assign stage_item[0].sat  = cfg.dsat[MAX_DEGREE];

   assign stage_valid[0] = req_valid;
   assign req_ready      = stage_ready[0];

   for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_step
      // step j folds in the term of power MAX_DEGREE-1-j
      localparam int K = MAX_DEGREE - 1 - j;

      logic [DATA_W-1:0] step_dcoef;
      logic              step_dsat;
      logic              step_deriv_en;

      // the derivative has no constant term: the last step leaves it alone
      if (K >= 1) begin : g_deriv
         assign step_dcoef    = cfg.dcoef[K];
         assign step_dsat     = cfg.dsat[K];
         assign step_deriv_en = 1'b1;
      end else begin : g_no_deriv
         assign step_dcoef    = '0;
         assign step_dsat     = 1'b0;
         assign step_deriv_en = 1'b0;
      end

      hps_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[j]),
         .in_ready  (stage_ready[j]),
         .in_item   (stage_item[j]),
         .coef      (cfg.coef[K]),
         .dcoef     (step_dcoef),
         .dsat      (step_dsat),
         .deriv_en  (step_deriv_en),
         .out_valid (stage_valid[j+1]),
         .out_ready (stage_ready[j+1]),
         .out_item  (stage_item[j+1])
      );
   end

   // slope stage doubles as the output register
   hps_slope u_slope (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[MAX_DEGREE]),
      .in_ready  (stage_ready[MAX_DEGREE]),
      .in_item   (stage_item[MAX_DEGREE]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_data)
   );

endmodule
